// ----- hdl/sss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_RATE_DEF = 48000;
  localparam int SINE_BITS_DEF   = 10;

  // Trigger handling.
  localparam logic [15:0] STRENGTH_MIN = 16'd6554;
  localparam logic [31:0] SEED_BOMB    = 32'hB0B5A11D;
  localparam logic [31:0] SEED_SPLASH  = 32'h5A1A5EED;

  // Mix weights and mode gains in Q1.15.
  localparam int W_LOW       = 17039;
  localparam int W_NOISE     = 9830;
  localparam int W_SLAP      = 5898;
  localparam int GAIN_BOMB   = 17039;
  localparam int GAIN_SPLASH = 9830;

  // Chirp and slap frequencies in Hz, and decay rates.
  localparam int F0_BOMB     = 92;
  localparam int F0_SPLASH   = 145;
  localparam int FS_BOMB     = 310;
  localparam int FS_SPLASH   = 420;
  localparam int DECAY_K_BOMB   = 10;
  localparam int DECAY_K_SPLASH = 18;

  // Unity in Q1.15 for the envelope and the slap decay.
  localparam logic [16:0] Q15_ONE = 17'd32768;

  // One command as it travels from the front end to the back end.
  typedef struct packed {
    logic        trig;
    logic [15:0] strength;
    logic        bomb;
  } cmd_t;

  // One entry of the full-period sine table, Q1.15, from a quarter-wave polynomial.
  function automatic logic signed [15:0] sine_entry(input int n, input int bits);
    int unsigned qb;
    int unsigned quad;
    int unsigned w;
    int unsigned x;
    int unsigned x2;
    int unsigned t;
    int unsigned r;
    logic signed [15:0] rs;
    qb   = bits - 2;
    quad = (n >> qb) & 3;
    w    = n & ((1 << qb) - 1);
    x    = w << (15 - qb);
    if (quad[0]) begin
      x = 32768 - x;
    end
    x2 = (x * x) >> 15;
    t  = (2383 * x2) >> 15;
    t  = 21056 - t;
    t  = (t * x2) >> 15;
    t  = 51470 - t;
    r  = (t * x) >> 15;
    if (r > 32767) begin
      r = 32767;
    end
    rs = 16'(r);
    return quad[1] ? -rs : rs;
  endfunction

  // Arithmetic right shift that rounds half away from zero.
  function automatic logic signed [35:0] rnd_shift(input logic signed [35:0] v, input int s);
    logic [35:0] mag;
    logic [35:0] half;
    logic [35:0] r;
    half = 36'd1 << (s - 1);
    mag  = v[35] ? 36'(-v) : 36'(v);
    r    = (mag + half) >> s;
    return v[35] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sss_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sss_div #(
  parameter int QW = 16,
  parameter int RW = 16
) (
  input  wire logic [QW-1:0] q,
  input  wire logic [RW-1:0] r,
  input  wire logic [QW-1:0] q_add,
  input  wire logic [RW-1:0] r_add,
  input  wire logic [RW-1:0] d,
  output logic [QW-1:0]      q_next,
  output logic [RW-1:0]      r_next
);

  logic [RW:0] sum;
  logic [RW:0] diff;

  // A quotient and remainder pair of a division by d, advanced by one addition.
  // The remainder stays below d; an overflow of it carries into the quotient.
  always_comb begin
    sum  = {1'b0, r} + {1'b0, r_add};
    diff = sum - {1'b0, d};
    if (sum >= {1'b0, d}) begin
      q_next = q + q_add + QW'(1);
      r_next = diff[RW-1:0];
    end else begin
      q_next = q + q_add;
      r_next = sum[RW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sss_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sss_front import sss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [15:0] strength,
  input  wire logic        bomb,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_pop
);

  cmd_t       entry [2];
  cmd_t       incoming;
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  // Classify the item and clamp the trigger strength.
  always_comb begin
    incoming.trig     = kind;
    incoming.strength = (strength < STRENGTH_MIN) ? STRENGTH_MIN : strength;
    incoming.bomb     = bomb;
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entry[rp];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entry[wp] <= incoming;
        wp        <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sss_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sss_back import sss_pkg::*; #(
  parameter int SAMPLE_RATE     = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      sample,
  output logic                    active,
  output logic                    last
);

  // Sound lengths and phase constants, worked out at elaboration.
  localparam longint LEN_S   = (longint'(SAMPLE_RATE) * 28) / 100;
  localparam longint LEN_B   = (longint'(SAMPLE_RATE) * 58 - 1) / 100;
  localparam longint DEN_S   = 100 * LEN_S * longint'(SAMPLE_RATE);
  localparam longint DEN_B   = 100 * LEN_B * longint'(SAMPLE_RATE);
  localparam longint D0_S    = F0_SPLASH * (100 * LEN_S - 62);
  localparam longint D0_B    = F0_BOMB * (100 * LEN_B - 62);
  localparam longint DD_S    = F0_SPLASH * 124;
  localparam longint DD_B    = F0_BOMB * 124;
  localparam longint STEP_S  = (65536 * DECAY_K_SPLASH + SAMPLE_RATE / 2) / SAMPLE_RATE;
  localparam longint STEP_B  = (65536 * DECAY_K_BOMB + SAMPLE_RATE / 2) / SAMPLE_RATE;
  localparam int FRAME_W     = $clog2(LEN_B + 1);
  localparam int DEN_W       = $clog2(DEN_B + 1);
  localparam int SR_W        = $clog2(SAMPLE_RATE + 1);
  localparam int SINE_DEPTH  = 1 << SINE_TABLE_BITS;
  localparam longint TB      = longint'(1) << SINE_TABLE_BITS;

  // Table index and remainder of the chirp phase step at frame zero.
  localparam longint CQ0_S   = (TB * D0_S) / DEN_S;
  localparam longint CR0_S   = (TB * D0_S) % DEN_S;
  localparam longint CQ0_B   = (TB * D0_B) / DEN_B;
  localparam longint CR0_B   = (TB * D0_B) % DEN_B;
  // Per-frame decrease of the chirp phase step.
  localparam longint CQD_S   = (TB * DD_S) / DEN_S;
  localparam longint CRD_S   = (TB * DD_S) % DEN_S;
  localparam longint CQD_B   = (TB * DD_B) / DEN_B;
  localparam longint CRD_B   = (TB * DD_B) % DEN_B;
  // Per-frame slap phase step.
  localparam longint SQ_S    = (TB * FS_SPLASH) / SAMPLE_RATE;
  localparam longint SRM_S   = (TB * FS_SPLASH) % SAMPLE_RATE;
  localparam longint SQ_B    = (TB * FS_BOMB) / SAMPLE_RATE;
  localparam longint SRM_B   = (TB * FS_BOMB) % SAMPLE_RATE;
  // Per-frame decrease of the envelope, 2^15 / length.
  localparam longint EQ_S    = 32768 / LEN_S;
  localparam longint ER_S    = 32768 % LEN_S;
  localparam longint EQ_B    = 32768 / LEN_B;
  localparam longint ER_B    = 32768 % LEN_B;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic signed [15:0] sine_rom [SINE_DEPTH];

  logic [1:0]                 state;
  logic [2:0]                 mstep;
  logic                       playing;
  logic                       mode_bomb;
  logic [15:0]                gain_strength;
  logic [31:0]                noise_register;
  logic [16:0]                slap_decay;
  logic [FRAME_W-1:0]         frame_index;
  logic [SINE_TABLE_BITS-1:0] idx_c;
  logic [DEN_W-1:0]           rem_c;
  logic [SINE_TABLE_BITS-1:0] cq;
  logic [DEN_W-1:0]           cr;
  logic [SINE_TABLE_BITS-1:0] idx_s;
  logic [SR_W-1:0]            rem_s;
  logic [15:0]                env;
  logic [FRAME_W-1:0]         env_rem;
  logic signed [15:0]         low_s;
  logic signed [15:0]         slap_s;
  logic signed [35:0]         acc;
  logic signed [17:0]         slapv;
  logic signed [17:0]         mix;
  logic signed [17:0]         v;
  logic signed [15:0]         result;

  logic                       out_free;
  logic                       out_set;
  logic [DEN_W-1:0]           den_sel;
  logic [FRAME_W-1:0]         len_sel;
  logic [SINE_TABLE_BITS-1:0] cd_q_add;
  logic [DEN_W-1:0]           cd_r_add;
  logic [SINE_TABLE_BITS-1:0] sl_q_add;
  logic [SR_W-1:0]            sl_r_add;
  logic [15:0]                en_q_add;
  logic [FRAME_W-1:0]         en_r_add;
  logic [SINE_TABLE_BITS-1:0] idx_c_next;
  logic [DEN_W-1:0]           rem_c_next;
  logic [SINE_TABLE_BITS-1:0] cq_next;
  logic [DEN_W-1:0]           cr_next;
  logic [SINE_TABLE_BITS-1:0] idx_s_next;
  logic [SR_W-1:0]            rem_s_next;
  logic [15:0]                env_next;
  logic [FRAME_W-1:0]         env_rem_next;
  logic [31:0]                nr0;
  logic [31:0]                nr1;
  logic [31:0]                noise_next;
  logic signed [15:0]         noise_s;
  logic signed [17:0]         ma;
  logic signed [17:0]         mb;
  logic signed [35:0]         prod;
  logic signed [35:0]         rsh;
  logic                       is_last;

  // Constant sine table.
  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  assign den_sel  = mode_bomb ? DEN_W'(DEN_B) : DEN_W'(DEN_S);
  assign len_sel  = mode_bomb ? FRAME_W'(LEN_B) : FRAME_W'(LEN_S);
  assign out_free = !out_valid || out_ready;
  assign is_last  = ({1'b0, frame_index} + 1'b1) >= {1'b0, len_sel};

  // Step constants of the current mode. A decrease by a quotient and a remainder
  // is added as one less quotient step and the divisor minus the remainder.
  assign cd_q_add = mode_bomb ? SINE_TABLE_BITS'(-CQD_B - 1) : SINE_TABLE_BITS'(-CQD_S - 1);
  assign cd_r_add = mode_bomb ? DEN_W'(DEN_B - CRD_B) : DEN_W'(DEN_S - CRD_S);
  assign sl_q_add = mode_bomb ? SINE_TABLE_BITS'(SQ_B) : SINE_TABLE_BITS'(SQ_S);
  assign sl_r_add = mode_bomb ? SR_W'(SRM_B) : SR_W'(SRM_S);
  assign en_q_add = mode_bomb ? 16'(-EQ_B - 1) : 16'(-EQ_S - 1);
  assign en_r_add = mode_bomb ? FRAME_W'(LEN_B - ER_B) : FRAME_W'(LEN_S - ER_S);

  // Chirp phase: table index and remainder, advanced by the current phase step.
  sss_div #(.QW(SINE_TABLE_BITS), .RW(DEN_W)) u_step_chirp (
    .q(idx_c), .r(rem_c), .q_add(cq), .r_add(cr), .d(den_sel),
    .q_next(idx_c_next), .r_next(rem_c_next)
  );

  // Chirp phase step, lowered every frame as the frequency falls.
  sss_div #(.QW(SINE_TABLE_BITS), .RW(DEN_W)) u_step_delta (
    .q(cq), .r(cr), .q_add(cd_q_add), .r_add(cd_r_add), .d(den_sel),
    .q_next(cq_next), .r_next(cr_next)
  );

  // Slap phase at a fixed frequency.
  sss_div #(.QW(SINE_TABLE_BITS), .RW(SR_W)) u_step_slap (
    .q(idx_s), .r(rem_s), .q_add(sl_q_add), .r_add(sl_r_add), .d(SR_W'(SAMPLE_RATE)),
    .q_next(idx_s_next), .r_next(rem_s_next)
  );

  // Linear fade-out envelope in Q1.15.
  sss_div #(.QW(16), .RW(FRAME_W)) u_step_env (
    .q(env), .r(env_rem), .q_add(en_q_add), .r_add(en_r_add), .d(len_sel),
    .q_next(env_next), .r_next(env_rem_next)
  );

  // Noise generator step (13, 17, 5) and its Q1.15 value.
  always_comb begin
    nr0        = noise_register ^ (noise_register << 13);
    nr1        = nr0 ^ (nr0 >> 17);
    noise_next = nr1 ^ (nr1 << 5);
  end
  assign noise_s = $signed({~noise_register[15], noise_register[14:0]});

  // Operand selection for the shared multiplier.
  always_comb begin
    case (mstep)
      3'd0: begin
        ma = 18'(low_s);
        mb = 18'(W_LOW);
      end
      3'd1: begin
        ma = 18'(noise_s);
        mb = 18'(W_NOISE);
      end
      3'd2: begin
        ma = 18'(slap_s);
        mb = $signed({1'b0, slap_decay});
      end
      3'd3: begin
        ma = slapv;
        mb = 18'(W_SLAP);
      end
      3'd4: begin
        ma = $signed({1'b0, slap_decay});
        mb = mode_bomb ? 18'(65536 - STEP_B) : 18'(65536 - STEP_S);
      end
      3'd5: begin
        ma = mix;
        mb = $signed({2'b00, env});
      end
      3'd6: begin
        ma = v;
        mb = $signed({2'b00, gain_strength});
      end
      default: begin
        ma = v;
        mb = mode_bomb ? 18'(GAIN_BOMB) : 18'(GAIN_SPLASH);
      end
    endcase
    prod = ma * mb;
  end

  // Rounding of the product for the current step, and final saturation.
  always_comb begin
    case (mstep)
      3'd3:    rsh = rnd_shift(acc + prod, 15);
      3'd6:    rsh = rnd_shift(prod, 16);
      default: rsh = rnd_shift(prod, 15);
    endcase
    if (rsh > 36'sd32767) begin
      result = 16'sh7FFF;
    end else if (rsh < -36'sd32768) begin
      result = -16'sh8000;
    end else begin
      result = rsh[15:0];
    end
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid && (cmd.trig || out_free);
  end

  // A result is loaded for an idle tick or at the end of a playing tick.
  assign out_set = ((state == ST_IDLE) && cmd_pop && !cmd.trig && !playing) ||
                   ((state == ST_OUT) && out_free);

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Voice sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mstep          <= '0;
      playing        <= 1'b0;
      mode_bomb      <= 1'b0;
      gain_strength  <= '0;
      noise_register <= '0;
      slap_decay     <= '0;
      frame_index    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.trig) begin
              gain_strength  <= cmd.strength;
              mode_bomb      <= cmd.bomb;
              noise_register <= cmd.bomb ? SEED_BOMB : SEED_SPLASH;
              slap_decay     <= Q15_ONE;
              frame_index    <= '0;
              playing        <= 1'b1;
              idx_c          <= '0;
              rem_c          <= '0;
              cq             <= cmd.bomb ? SINE_TABLE_BITS'(CQ0_B) : SINE_TABLE_BITS'(CQ0_S);
              cr             <= cmd.bomb ? DEN_W'(CR0_B) : DEN_W'(CR0_S);
              idx_s          <= '0;
              rem_s          <= '0;
              env            <= Q15_ONE[15:0];
              env_rem        <= '0;
            end else if (!playing) begin
              sample <= '0;
              active <= 1'b0;
              last   <= 1'b0;
            end else begin
              noise_register <= noise_next;
              state          <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          low_s  <= sine_rom[idx_c];
          slap_s <= sine_rom[idx_s];
          mstep  <= '0;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          case (mstep)
            3'd0: acc <= prod;
            3'd1: acc <= acc + prod;
            3'd2: slapv <= rsh[17:0];
            3'd3: mix <= rsh[17:0];
            3'd4: slap_decay <= prod[32:16];
            3'd5: v <= rsh[17:0];
            3'd6: v <= rsh[17:0];
            default: v <= 18'(result);
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd7) begin
            state <= ST_OUT;
          end
        end
        default: begin
          if (out_free) begin
            sample  <= v[15:0];
            active  <= 1'b1;
            last    <= is_last;
            idx_c   <= idx_c_next;
            rem_c   <= rem_c_next;
            cq      <= cq_next;
            cr      <= cr_next;
            idx_s   <= idx_s_next;
            rem_s   <= rem_s_next;
            env     <= env_next;
            env_rem <= env_rem_next;
            if (is_last) begin
              playing     <= 1'b0;
              frame_index <= '0;
            end else begin
              frame_index <= frame_index + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/splash_sound_synth_top.sv -----
// Path: a tick while a sound plays goes from the queue through the idle state, the table
// lookup, 8 multiply steps on the shared multiplier and the output register, which
// waits on out_ready. The back end takes no new command until a playing tick leaves
// its output state; idle ticks and triggers are taken without leaving the idle state.
// Reset: synchronous, active high; the voice is idle and the queue is empty after it.
`timescale 1ns / 1ps
`default_nettype none
module splash_sound_synth_top import sss_pkg::*; #(
  parameter int SAMPLE_RATE     = SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [15:0]        strength,
  input  wire logic               bomb,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      sample,
  output logic                    active,
  output logic                    last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: accepts transfers, classifies them and queues commands.
  sss_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .strength(strength), .bomb(bomb),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  // Back end: runs the voice and holds the output register.
  sss_back #(
    .SAMPLE_RATE(SAMPLE_RATE),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .active(active), .last(last)
  );

endmodule
`default_nettype wire
